// File: rtl/ulc_pkg.sv
package ulc_pkg;

  localparam int unsigned CpW = 21;

  localparam logic [7:0] LeadMask2 = 8'hE0;
  localparam logic [7:0] LeadMask3 = 8'hF0;
  localparam logic [7:0] LeadMask4 = 8'hF8;
  localparam logic [7:0] Lead2     = 8'hC0;
  localparam logic [7:0] Lead3     = 8'hE0;
  localparam logic [7:0] Lead4     = 8'hF0;
  localparam logic [7:0] ContMask  = 8'hC0;
  localparam logic [7:0] ContTag   = 8'h80;

  localparam logic [2:0] SeqLen2 = 3'd2;
  localparam logic [2:0] SeqLen3 = 3'd3;
  localparam logic [2:0] SeqLen4 = 3'd4;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      n;
  } enc_t;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      n;
    logic            last;
  } grp_t;

  function automatic logic [CpW-1:0] lower_cp(input logic [CpW-1:0] c);
    logic [CpW-1:0] r;
    r = c;
    if (c inside {[21'h41 : 21'h5A]}) begin
      r = c + 21'd32;
    end else if (c inside {[21'hC0 : 21'hD6], [21'hD8 : 21'hDE]}) begin
      r = c + 21'd32;
    end else if (c inside {[21'h100 : 21'h137]}) begin
      r = c[0] ? c : c + 21'd1;
    end else if (c inside {[21'h139 : 21'h148]}) begin
      r = c[0] ? c + 21'd1 : c;
    end else if (c inside {[21'h14A : 21'h177]}) begin
      r = c[0] ? c : c + 21'd1;
    end else if (c == 21'h178) begin
      r = 21'h0FF;
    end else if (c inside {[21'h179 : 21'h17E]}) begin
      r = c[0] ? c + 21'd1 : c;
    end else if (c inside {[21'h391 : 21'h3A1], [21'h3A3 : 21'h3AB]}) begin
      r = c + 21'd32;
    end else begin
      case (c)
        21'h386: r = 21'h3AC;
        21'h388: r = 21'h3AD;
        21'h389: r = 21'h3AE;
        21'h38A: r = 21'h3AF;
        21'h38C: r = 21'h3CC;
        21'h38E: r = 21'h3CD;
        21'h38F: r = 21'h3CE;
        default: begin
          if (c inside {[21'h410 : 21'h42F]}) begin
            r = c + 21'd32;
          end else if (c inside {[21'h400 : 21'h40F]}) begin
            r = c + 21'd80;
          end
        end
      endcase
    end
    return r;
  endfunction

  function automatic enc_t encode_cp(input logic [CpW-1:0] c);
    enc_t e;
    e = '0;
    if (c < 21'h80) begin
      e.bytes[0] = c[7:0];
      e.n        = 3'd1;
    end else if (c < 21'h800) begin
      e.bytes[0] = {3'b110, c[10:6]};
      e.bytes[1] = {2'b10, c[5:0]};
      e.n        = 3'd2;
    end else if (c < 21'h10000) begin
      e.bytes[0] = {4'b1110, c[15:12]};
      e.bytes[1] = {2'b10, c[11:6]};
      e.bytes[2] = {2'b10, c[5:0]};
      e.n        = 3'd3;
    end else begin
      e.bytes[0] = {5'b11110, c[20:18]};
      e.bytes[1] = {2'b10, c[17:12]};
      e.bytes[2] = {2'b10, c[11:6]};
      e.bytes[3] = {2'b10, c[5:0]};
      e.n        = 3'd4;
    end
    return e;
  endfunction

endpackage

// File: rtl/ulc_in_if.sv
interface ulc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

// File: rtl/ulc_out_if.sv
interface ulc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

// File: rtl/ulc_recode.sv
module ulc_recode (
  input  logic [ulc_pkg::CpW-1:0] cp_i,
  output ulc_pkg::enc_t           enc_o
);

  assign enc_o = ulc_pkg::encode_cp(ulc_pkg::lower_cp(cp_i));

endmodule

// File: rtl/ulc_decode.sv
module ulc_decode (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic [7:0]    byte_i,
  input  logic          last_i,
  output ulc_pkg::grp_t grp_o
);

  logic [7:0]              pend_q [3];
  logic [1:0]              cnt_q, cnt_d;
  logic [2:0]              exp_q, exp_d;
  logic [ulc_pkg::CpW-1:0] acc_q, acc_d;

  logic                    cont;
  logic [ulc_pkg::CpW-1:0] acc_new;
  logic [ulc_pkg::CpW-1:0] rc_cp;
  ulc_pkg::enc_t           enc;
  logic [2:0]              lead_len;
  logic [ulc_pkg::CpW-1:0] lead_bits;
  logic                    pend_wr;
  logic [1:0]              pend_idx;
  logic [1:0]              pre_n;
  logic [7:0]              extra;
  logic                    has_extra;
  logic                    use_enc;

  assign cont    = (byte_i & ulc_pkg::ContMask) == ulc_pkg::ContTag;
  assign acc_new = {acc_q[ulc_pkg::CpW-7:0], byte_i[5:0]};
  assign rc_cp   = (cnt_q != 2'd0 && cont) ? acc_new : {13'd0, byte_i};

  ulc_recode u_recode (
    .cp_i  (rc_cp),
    .enc_o (enc)
  );

  always_comb begin
    lead_len  = 3'd0;
    lead_bits = '0;
    if ((byte_i & ulc_pkg::LeadMask2) == ulc_pkg::Lead2) begin
      lead_len  = ulc_pkg::SeqLen2;
      lead_bits = {16'd0, byte_i[4:0]};
    end else if ((byte_i & ulc_pkg::LeadMask3) == ulc_pkg::Lead3) begin
      lead_len  = ulc_pkg::SeqLen3;
      lead_bits = {17'd0, byte_i[3:0]};
    end else if ((byte_i & ulc_pkg::LeadMask4) == ulc_pkg::Lead4) begin
      lead_len  = ulc_pkg::SeqLen4;
      lead_bits = {18'd0, byte_i[2:0]};
    end
  end

  always_comb begin
    cnt_d     = cnt_q;
    exp_d     = exp_q;
    acc_d     = acc_q;
    pend_wr   = 1'b0;
    pend_idx  = cnt_q;
    pre_n     = 2'd0;
    extra     = byte_i;
    has_extra = 1'b0;
    use_enc   = 1'b0;
    if (cnt_q != 2'd0 && cont) begin
      if ({1'b0, cnt_q} + 3'd1 >= exp_q) begin
        use_enc = 1'b1;
        cnt_d   = 2'd0;
        exp_d   = 3'd0;
        acc_d   = '0;
      end else if (last_i) begin
        pre_n     = cnt_q;
        has_extra = 1'b1;
      end else begin
        pend_wr = 1'b1;
        cnt_d   = cnt_q + 2'd1;
        acc_d   = acc_new;
      end
    end else begin
      // flush whatever was gathered, then take the byte fresh
      pre_n = cnt_q;
      cnt_d = 2'd0;
      exp_d = 3'd0;
      acc_d = '0;
      if (!byte_i[7]) begin
        has_extra = 1'b1;
        extra     = enc.bytes[0];
      end else if (lead_len != 3'd0) begin
        if (last_i) begin
          has_extra = 1'b1;
        end else begin
          pend_wr  = 1'b1;
          pend_idx = 2'd0;
          cnt_d    = 2'd1;
          exp_d    = lead_len;
          acc_d    = lead_bits;
        end
      end else begin
        has_extra = 1'b1;
      end
    end
    if (last_i) begin
      cnt_d = 2'd0;
      exp_d = 3'd0;
      acc_d = '0;
    end
  end

  always_comb begin
    grp_o.last = last_i;
    if (use_enc) begin
      grp_o.bytes = enc.bytes;
      grp_o.n     = enc.n;
    end else begin
      grp_o.bytes[0] = (pre_n > 2'd0) ? pend_q[0] : extra;
      grp_o.bytes[1] = (pre_n > 2'd1) ? pend_q[1] : extra;
      grp_o.bytes[2] = (pre_n > 2'd2) ? pend_q[2] : extra;
      grp_o.bytes[3] = extra;
      grp_o.n        = {1'b0, pre_n} + {2'd0, has_extra};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      exp_q <= 3'd0;
      acc_q <= '0;
    end else if (accept_i) begin
      cnt_q <= cnt_d;
      exp_q <= exp_d;
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && pend_wr) begin
      pend_q[pend_idx] <= byte_i;
    end
  end

endmodule

// File: rtl/ulc_out_buf.sv
module ulc_out_buf (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  ulc_pkg::grp_t grp_i,
  input  logic          ready_i,
  output logic          valid_o,
  output logic [7:0]    byte_o,
  output logic          last_o,
  output logic          room_o
);

  logic [3:0][7:0] bytes_q;
  logic            last_q;
  logic [2:0]      rem_q, rem_d;
  logic [1:0]      idx_q, idx_d;
  logic            pop;

  assign valid_o = rem_q != 3'd0;
  assign pop     = valid_o && ready_i;
  assign room_o  = (rem_q == 3'd0) || (rem_q == 3'd1 && ready_i);
  assign byte_o  = bytes_q[idx_q];
  assign last_o  = last_q && (rem_q == 3'd1);

  always_comb begin
    rem_d = rem_q;
    idx_d = idx_q;
    if (load_i) begin
      rem_d = grp_i.n;
      idx_d = 2'd0;
    end else if (pop) begin
      rem_d = rem_q - 3'd1;
      idx_d = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= 3'd0;
      idx_q <= 2'd0;
    end else begin
      rem_q <= rem_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bytes_q <= grp_i.bytes;
      last_q  <= grp_i.last;
    end
  end

endmodule

// File: rtl/utf8_lowercase_stream.sv
// channel  dir  fields              accepted when
// in_i     in   in_byte, in_last    in_i.valid && in_i.ready
// out_o    out  out_byte, out_last  out_o.valid && out_o.ready
//
// one input item per cycle while in_i.ready is high; the item is decoded,
// lowercased and re-encoded in the cycle it is taken, and its 0 to 4 bytes
// land in the output buffer, which sends one byte per cycle while out_o.ready
// is high; in_i.ready is low until the last buffered byte is sent, so items
// with no bytes never stall; it also drops while out_o.ready is low and a byte waits
// rst_ni clears the gathered sequence and empties the buffer
module utf8_lowercase_stream (
  input  logic clk_i,
  input  logic rst_ni,
  ulc_in_if.sink    in_i,
  ulc_out_if.source out_o
);

  ulc_pkg::grp_t grp;
  logic          room;
  logic          accept;

  assign in_i.ready = room;
  assign accept     = in_i.valid && room;

  ulc_decode u_decode (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (in_i.in_byte),
    .last_i   (in_i.in_last),
    .grp_o    (grp)
  );

  ulc_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (accept),
    .grp_i   (grp),
    .ready_i (out_o.ready),
    .valid_o (out_o.valid),
    .byte_o  (out_o.out_byte),
    .last_o  (out_o.out_last),
    .room_o  (room)
  );

endmodule
